/* design/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clock, disabled while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, with the antecedent and consequent given apart.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  `ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

/* design/b32d_pkg.sv */
package b32d_pkg;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] FIRST_CHAR = 8'h32;
  localparam int         MAP_SIZE   = 41;
  localparam logic [7:0] NO_DIGIT   = 8'hFF;
  localparam logic [3:0] MAX_PADS   = 4'd7;

  // Digit values for the characters '2' through 'Z'.
  localparam logic [7:0] DIGIT_MAP [MAP_SIZE] = '{
    8'd26, 8'd27, 8'd28, 8'd29, 8'd30, 8'd31, NO_DIGIT, NO_DIGIT,
    NO_DIGIT, NO_DIGIT, NO_DIGIT, NO_DIGIT, NO_DIGIT, NO_DIGIT, NO_DIGIT,
    8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10,
    8'd11, 8'd12, 8'd13, 8'd14, 8'd15, 8'd16, 8'd17, 8'd18, 8'd19, 8'd20,
    8'd21, 8'd22, 8'd23, 8'd24, 8'd25
  };

  function automatic logic [7:0] to_digit(input logic [7:0] c);
    logic [7:0] offs;
    offs = c - FIRST_CHAR;
    if (c >= FIRST_CHAR && offs < 8'(MAP_SIZE)) begin
      return DIGIT_MAP[offs[5:0]];
    end
    return NO_DIGIT;
  endfunction

endpackage

/* design/base32_stream_decoder.sv */
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_stall   in_character, in_last
// out_      output     out_valid / out_stall out_data_byte, out_has_byte,
//                                            out_end_of_string, out_error
// cfg_      input      cfg_valid / cfg_ready cfg_require_padding
//
// One character is taken per cycle; its result, if any, appears in the output
// register on the next cycle. The single output register sets the rate: a new
// character is taken whenever that register is empty or is drained in the same
// cycle. Reset (rst_n low, synchronous) clears the string state, the mode bit
// and the output valid bit. A stalled output holds its transfer and stalls input.
module base32_stream_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_character,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic       out_has_byte,
  output logic       out_end_of_string,
  output logic       out_error,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_require_padding
);
  import b32d_pkg::*;

  logic       require_padding_r;
  logic [7:0] partial_r, partial_nxt;
  logic [2:0] data_pos_r, data_pos_nxt;
  logic [2:0] total_pos_r, total_pos_nxt;
  logic [3:0] pad_count_r, pad_count_nxt;
  logic       in_padding_r, in_padding_nxt;
  logic       error_seen_r, error_seen_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_byte_r, out_data_byte_nxt;
  logic       out_has_byte_r, out_has_byte_nxt;
  logic       out_eos_r, out_eos_nxt;
  logic       out_error_r, out_error_nxt;

  logic        accept;
  logic        out_free;
  logic [7:0]  digit;
  logic [2:0]  held;
  logic [3:0]  n_full;
  logic [2:0]  n_left;
  logic [12:0] acc;
  logic [7:0]  mask;
  logic [7:0]  byte_val;
  logic        byte_ready;
  logic        str_err;
  logic        produce;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !out_free;
  assign accept   = in_valid && out_free;
  assign cfg_ready = 1'b1;

  always_comb begin
    digit         = to_digit(in_character);
    total_pos_nxt = total_pos_r + 3'd1;
    partial_nxt   = partial_r;
    data_pos_nxt  = data_pos_r;
    pad_count_nxt = pad_count_r;
    in_padding_nxt = in_padding_r;
    error_seen_nxt = error_seen_r;
    byte_ready    = 1'b0;
    byte_val      = 8'd0;

    // Bits already held before this digit: 5 * position, mod 8.
    held   = data_pos_r + {data_pos_r[0], 2'b00};
    n_full = {1'b0, held} + 4'd5;
    acc    = {partial_r, digit[4:0]};
    n_left = n_full[3] ? 3'(n_full - 4'd8) : n_full[2:0];
    mask   = 8'((9'd1 << n_left) - 9'd1);

    if (!error_seen_r) begin
      if (in_padding_r) begin
        if (in_character == PAD_CHAR) begin
          pad_count_nxt = pad_count_r + 4'd1;
          if (pad_count_nxt > MAX_PADS) begin
            error_seen_nxt = 1'b1;
          end
        end else begin
          error_seen_nxt = 1'b1;
        end
      end else if (in_character == PAD_CHAR && require_padding_r) begin
        in_padding_nxt = 1'b1;
        pad_count_nxt  = 4'd1;
      end else if (digit == NO_DIGIT) begin
        error_seen_nxt = 1'b1;
      end else begin
        if (n_full[3]) begin
          byte_val   = 8'(acc >> n_left);
          byte_ready = 1'b1;
        end
        partial_nxt  = acc[7:0] & mask;
        data_pos_nxt = data_pos_r + 3'd1;
      end
    end

    str_err = error_seen_nxt || (require_padding_r && total_pos_nxt != 3'd0) ||
              (data_pos_nxt inside {3'd1, 3'd3, 3'd6}) || partial_nxt != 8'd0;

    produce           = in_last || byte_ready;
    out_has_byte_nxt  = byte_ready && !(in_last && str_err);
    out_data_byte_nxt = out_has_byte_nxt ? byte_val : 8'd0;
    out_eos_nxt       = in_last;
    out_error_nxt     = in_last && str_err;
    out_valid_nxt     = accept && produce;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      require_padding_r <= 1'b0;
      partial_r    <= 8'd0;
      data_pos_r   <= 3'd0;
      total_pos_r  <= 3'd0;
      pad_count_r  <= 4'd0;
      in_padding_r <= 1'b0;
      error_seen_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        require_padding_r <= cfg_require_padding;
      end
      if (accept) begin
        if (in_last) begin
          partial_r    <= 8'd0;
          data_pos_r   <= 3'd0;
          total_pos_r  <= 3'd0;
          pad_count_r  <= 4'd0;
          in_padding_r <= 1'b0;
          error_seen_r <= 1'b0;
        end else begin
          partial_r    <= partial_nxt;
          data_pos_r   <= data_pos_nxt;
          total_pos_r  <= total_pos_nxt;
          pad_count_r  <= pad_count_nxt;
          in_padding_r <= in_padding_nxt;
          error_seen_r <= error_seen_nxt;
        end
      end
      if (out_free) begin
        out_valid_r <= out_valid_nxt;
      end
    end
  end

  // Payload needs no reset; it loads only when the output register is free.
  always_ff @(posedge clk) begin
    if (out_free && out_valid_nxt) begin
      out_data_byte_r <= out_data_byte_nxt;
      out_has_byte_r  <= out_has_byte_nxt;
      out_eos_r       <= out_eos_nxt;
      out_error_r     <= out_error_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_data_byte     = out_data_byte_r;
  assign out_has_byte      = out_has_byte_r;
  assign out_end_of_string = out_eos_r;
  assign out_error         = out_error_r;

endmodule

/* design/b32d_checker.sv */
`include "assert_macros.svh"

module b32d_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_data_byte,
  input logic       out_has_byte,
  input logic       out_end_of_string,
  input logic       out_error
);

  // A stalled result transfer stays offered with the same byte.
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data_byte), "stalled output changed")

  // Input is stalled only while a result waits.
  `ASSERT_IMP(a_in_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without a waiting result")

  // An error is reported only at the end of a string.
  `ASSERT_IMP(a_err_at_end, clk, rst_n, out_valid && out_error, out_end_of_string, "error without end of string")

  // A rejected string never releases its final byte.
  `ASSERT_IMP(a_err_no_byte, clk, rst_n, out_valid && out_error, !out_has_byte, "byte given with error")

  // Mid-string results exist only to carry a byte.
  `ASSERT_IMP(a_mid_has_byte, clk, rst_n, out_valid && !out_end_of_string, out_has_byte, "empty mid-string result")

endmodule

bind base32_stream_decoder b32d_checker u_b32d_checker (.*);
